### rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// shared types for the tga rle pixel stream decoder: token kinds and the
// token record passed from the parser through the queue to the output stage
// ----------------------------------------------------------------------------
package tgarle_pkg;

  typedef enum logic [1:0] {
    TOK_PIXEL   = 2'd0,
    TOK_HDR_OK  = 2'd1,
    TOK_HDR_BAD = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        top_down;
  } tok_t;

  localparam int unsigned OUT_DATA_W = 80;

endpackage

### rtl/tgarle_front.sv
// ----------------------------------------------------------------------------
// tgarle_front
// byte parser: walks the 18-byte header, skips the id field, splits rle
// packets and assembles pixels; emits at most one token per accepted word
// ----------------------------------------------------------------------------
module tgarle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        din,
  input  logic              file_start,
  output logic              push,
  output tgarle_pkg::tok_t  tok
);
  import tgarle_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_IDSKIP = 3'd1,
    PH_PACKET = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_IDLE   = 3'd4
  } phase_t;

  localparam logic [4:0] HB_ID_LEN  = 5'd0;
  localparam logic [4:0] HB_TYPE    = 5'd2;
  localparam logic [4:0] HB_WIDTH_L = 5'd12;
  localparam logic [4:0] HB_WIDTH_H = 5'd13;
  localparam logic [4:0] HB_HEIGHT_L = 5'd14;
  localparam logic [4:0] HB_HEIGHT_H = 5'd15;
  localparam logic [4:0] HB_DEPTH   = 5'd16;
  localparam logic [4:0] HB_DESC    = 5'd17;
  localparam logic [7:0] TYPE_RAW   = 8'd2;
  localparam logic [7:0] TYPE_RLE   = 8'd10;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [1:0] LAST_BYTE  = 2'd3;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [4:0]  hidx_r, hidx_nxt, hidx_cur;
  logic [7:0]  id_left_r, id_left_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        comp_r, comp_nxt;
  logic [31:0] pix_left_r, pix_left_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [1:0]  pbyte_r, pbyte_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic        bad_r, bad_nxt;
  logic        td_r, td_nxt;
  logic [31:0] area_r, area_nxt;
  logic        emit;
  tok_t        tok_c;
  logic [7:0]  rep;
  logic [7:0]  r_c, g_c, b_c;

  always_comb begin
    phase_cur    = file_start ? PH_HEADER : phase_r;
    hidx_cur     = file_start ? '0 : hidx_r;
    phase_nxt    = phase_cur;
    hidx_nxt     = hidx_cur;
    bad_nxt      = file_start ? 1'b0 : bad_r;
    id_left_nxt  = id_left_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    comp_nxt     = comp_r;
    pix_left_nxt = pix_left_r;
    run_nxt      = run_r;
    pkt_left_nxt = pkt_left_r;
    pbyte_nxt    = pbyte_r;
    asm_nxt      = asm_r;
    td_nxt       = td_r;
    area_nxt     = area_r;
    emit         = 1'b0;
    tok_c        = '0;
    rep          = 8'd1;
    r_c          = asm_r[7:0];
    g_c          = asm_r[15:8];
    b_c          = asm_r[23:16];
    case (phase_cur)
      PH_HEADER: begin
        case (hidx_cur)
          HB_ID_LEN: id_left_nxt = din;
          HB_TYPE: begin
            if (din != TYPE_RAW && din != TYPE_RLE) bad_nxt = 1'b1;
            comp_nxt = (din == TYPE_RLE);
          end
          HB_WIDTH_L:  width_nxt  = {width_r[15:8], din};
          HB_WIDTH_H:  width_nxt  = {din, width_r[7:0]};
          HB_HEIGHT_L: height_nxt = {height_r[15:8], din};
          HB_HEIGHT_H: height_nxt = {din, height_r[7:0]};
          HB_DEPTH: begin
            if (din != DEPTH_32) bad_nxt = 1'b1;
            area_nxt = width_r * height_r;
          end
          HB_DESC: begin
            if (din[7:6] != 2'b00) bad_nxt = 1'b1;
            td_nxt = din[5];
          end
          default: ;
        endcase
        if (hidx_cur != HB_DESC) begin
          hidx_nxt = hidx_cur + 5'd1;
        end else begin
          hidx_nxt           = '0;
          emit               = 1'b1;
          tok_c.image_width  = width_r;
          tok_c.image_height = height_r;
          tok_c.top_down     = td_nxt;
          if (bad_nxt) begin
            phase_nxt  = PH_IDLE;
            tok_c.kind = TOK_HDR_BAD;
          end else begin
            tok_c.kind       = TOK_HDR_OK;
            tok_c.image_done = (area_r == '0);
            pix_left_nxt     = area_r;
            pbyte_nxt        = '0;
            pkt_left_nxt     = '0;
            run_nxt          = 1'b0;
            if (area_r == '0) phase_nxt = PH_IDLE;
            else if (id_left_r != '0) phase_nxt = PH_IDSKIP;
            else phase_nxt = comp_r ? PH_PACKET : PH_PIXEL;
          end
        end
      end
      PH_IDSKIP: begin
        id_left_nxt = id_left_r - 8'd1;
        if (id_left_nxt == '0) phase_nxt = comp_r ? PH_PACKET : PH_PIXEL;
      end
      PH_PACKET: begin
        run_nxt      = din[7];
        pkt_left_nxt = {1'b0, din[6:0]} + 8'd1;
        pbyte_nxt    = '0;
        phase_nxt    = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (pbyte_r != LAST_BYTE) begin
          case (pbyte_r)
            2'd0:    asm_nxt[7:0]   = din;
            2'd1:    asm_nxt[15:8]  = din;
            default: asm_nxt[23:16] = din;
          endcase
          pbyte_nxt = pbyte_r + 2'd1;
        end else begin
          pbyte_nxt = '0;
          if (comp_r && run_r) begin
            r_c = asm_r[7:0] & 8'hf8;
            g_c = asm_r[15:8] & 8'hfc;
            b_c = asm_r[23:16] & 8'hf8;
            rep = ({24'd0, pkt_left_r} < pix_left_r) ? pkt_left_r : pix_left_r[7:0];
            pix_left_nxt = pix_left_r - {24'd0, rep};
            pkt_left_nxt = '0;
          end else begin
            if (pix_left_r != '0) pix_left_nxt = pix_left_r - 32'd1;
            if (comp_r && pkt_left_r != '0) pkt_left_nxt = pkt_left_r - 8'd1;
          end
          if (pix_left_nxt == '0) phase_nxt = PH_IDLE;
          else if (comp_r && pkt_left_nxt == '0) phase_nxt = PH_PACKET;
          emit               = 1'b1;
          tok_c.kind         = TOK_PIXEL;
          tok_c.red          = r_c;
          tok_c.green        = g_c;
          tok_c.blue         = b_c;
          tok_c.alpha        = din;
          tok_c.repeat_count = rep;
          tok_c.image_done   = (pix_left_nxt == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hidx_r     <= '0;
      id_left_r  <= '0;
      width_r    <= '0;
      height_r   <= '0;
      comp_r     <= 1'b0;
      pix_left_r <= '0;
      run_r      <= 1'b0;
      pkt_left_r <= '0;
      pbyte_r    <= '0;
      asm_r      <= '0;
      bad_r      <= 1'b0;
      td_r       <= 1'b0;
      area_r     <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      id_left_r  <= id_left_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      comp_r     <= comp_nxt;
      pix_left_r <= pix_left_nxt;
      run_r      <= run_nxt;
      pkt_left_r <= pkt_left_nxt;
      pbyte_r    <= pbyte_nxt;
      asm_r      <= asm_nxt;
      bad_r      <= bad_nxt;
      td_r       <= td_nxt;
      area_r     <= area_nxt;
    end
  end

  assign push = accept && emit;
  assign tok  = tok_c;

  a_hdr_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    hidx_r <= HB_DESC)
    else $error("header byte index out of range");

  a_pixel_tok_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && tok_c.kind == TOK_PIXEL) |-> (tok_c.repeat_count != '0))
    else $error("pixel token with zero repeat count");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push && tok_c.image_done && !file_start) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after image done");

endmodule

### rtl/tgarle_queue.sv
// ----------------------------------------------------------------------------
// tgarle_queue
// small token fifo between the parser and the output stage
// ----------------------------------------------------------------------------
module tgarle_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tgarle_pkg::tok_t  push_tok,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output tgarle_pkg::tok_t  head_tok
);
  import tgarle_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_tok;
  end

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_tok = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

### rtl/tgarle_back.sv
// ----------------------------------------------------------------------------
// tgarle_back
// output stage: pulls tokens from the queue into a register and packs them
// onto the result stream
// ----------------------------------------------------------------------------
module tgarle_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  tgarle_pkg::tok_t                   q_tok,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tgarle_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast
);
  import tgarle_pkg::*;

  logic valid_r, valid_nxt;
  tok_t tok_r;

  assign q_pop = !q_empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) tok_r <= q_tok;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = tok_r.kind;
  assign out_tlast  = tok_r.image_done;
  assign out_tdata  = {7'd0, tok_r.top_down, tok_r.image_height, tok_r.image_width,
                       tok_r.repeat_count, tok_r.alpha, tok_r.blue, tok_r.green,
                       tok_r.red};

endmodule

### rtl/tga_rle_pixel_stream_decoder.sv
// a token passes from the parser through the fifo and the output register before it shows on out_*
// throughput: one input word per cycle while in_tready is high, at most one token per word
// the parser writes tokens into a small fifo; a registered output stage drains it
// input ready drops only when the fifo is full under output backpressure
// reset (synchronous, rst_n low) clears parser state and empties fifo and output
// ----------------------------------------------------------------------------
// tga_rle_pixel_stream_decoder
// decodes a 32-bit tga file byte stream (raw or rle) into header and pixel
// tokens
// ----------------------------------------------------------------------------
module tga_rle_pixel_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // data_byte
  input  logic                               in_tuser,   // file_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red, green, blue, alpha, repeat_count, image_width, image_height, top_down
  output logic [tgarle_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                         out_tuser,  // token_kind
  output logic                               out_tlast   // image_done
);
  import tgarle_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  tok_t front_tok;
  tok_t head_tok;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  tgarle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .din        (in_tdata),
    .file_start (in_tuser),
    .push       (push),
    .tok        (front_tok)
  );

  tgarle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (front_tok),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head_tok (head_tok)
  );

  tgarle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_tok      (head_tok),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
